[design/ils_pkg.sv]
// Shared types and constants of the indexed list store.
package ils_pkg;

    localparam int KIND_W         = 4;
    localparam int POS_IN_W       = 5;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int POS_OUT_W      = 4;
    localparam int OCC_W          = 5;
    localparam int CAPACITY_DFLT  = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_INS_FRONT = 4'd0,
        KIND_INS_END   = 4'd1,
        KIND_INS_AT    = 4'd2,
        KIND_DEL_FRONT = 4'd3,
        KIND_DEL_END   = 4'd4,
        KIND_DEL_AT    = 4'd5,
        KIND_READ      = 4'd6,
        KIND_WRITE     = 4'd7,
        KIND_SEARCH    = 4'd8
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_TAKE_LEFT,
        CELL_TAKE_RIGHT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [VALUE_W-1:0]  load_value;
    } cell_cmd_t;

endpackage

[design/ils_if.sv]
// Request and response channel interfaces of the indexed list store.
interface ils_req_if;
    import ils_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic [POS_IN_W-1:0]        position_in;
    logic signed [VALUE_W-1:0]  value_in;

    modport source (output valid, output kind, output position_in, output value_in,
                    input ready);
    modport sink   (input valid, input kind, input position_in, input value_in,
                    output ready);
endinterface

interface ils_rsp_if;
    import ils_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [POS_OUT_W-1:0]       position_out;
    logic signed [VALUE_W-1:0]  value_out;
    logic [OCC_W-1:0]           occupancy;

    modport source (output valid, output status, output position_out, output value_out,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input position_out, input value_out,
                    input occupancy, output ready);
endinterface

[design/ils_cell.sv]
// One storage cell of the list chain: holds one entry and compares it to a key.
module ils_cell (
    input  logic                               clk,
    input  ils_pkg::cell_cmd_t                 cmd,
    input  logic signed [ils_pkg::VALUE_W-1:0] left_value,
    input  logic signed [ils_pkg::VALUE_W-1:0] right_value,
    input  logic signed [ils_pkg::VALUE_W-1:0] key,
    output logic signed [ils_pkg::VALUE_W-1:0] value,
    output logic                               match
);
    import ils_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    always_comb
    begin
        case (cmd.op)
            CELL_LOAD:       value_next = cmd.load_value;
            CELL_TAKE_LEFT:  value_next = left_value;
            CELL_TAKE_RIGHT: value_next = right_value;
            default:         value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign match = (value_reg == key);

endmodule

[design/indexed_list_store_core.sv]
// Top level of the indexed list store: request control and the chain of cells.
// Channels: req (sink) takes one request per handshake: kind, position_in, value_in.
//   rsp (source) returns exactly one response per request: status, position_out,
//   value_out and occupancy (entry count after the request).
// The list lives in a chain of CAPACITY cells; entry i sits in cell i. Inserts
// shift the cells above the insert point up by one, deletes shift them down,
// writes load a single cell and a search compares every cell at once against
// the key, with the lowest matching cell winning.
// Timing: a request accepted at edge t executes in the following cycle; with rsp
//   free its response is registered at the end of that cycle and shows on rsp
//   from then on. Each request passes accept, then execute, and no new request
//   is taken until the last one has executed; the execute cycle is set by the shift
//   and compare of the whole cell chain plus the selection of one cell's value.
//   req.ready is low while a request executes.
// Stall: while the receiver holds rsp, the execute step waits and the cell chain
//   holds; once the response is taken the next one is written in the same cycle.
// Reset: rst_n clears the entry count and empties the response register. Cell
//   contents are not cleared; only entries below the count are ever read.
module indexed_list_store_core #(
    parameter int CAPACITY = ils_pkg::CAPACITY_DFLT
) (
    input  logic      clk,
    input  logic      rst_n,
    ils_req_if.sink   req,
    ils_rsp_if.source rsp
);
    import ils_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > POS_IN_W) ? CW : POS_IN_W) + 1;
    localparam logic [CMPW-1:0] CAP_EXT = CMPW'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_INSERT,
        MODE_DELETE,
        MODE_WRITE
    } mode_t;

    state_t                    state_reg;
    logic [KIND_W-1:0]         req_kind_reg;
    logic [POS_IN_W-1:0]       req_pos_reg;
    logic signed [VALUE_W-1:0] req_value_reg;
    logic [CW-1:0]             count_reg;
    logic                      rsp_valid_reg;
    logic [STATUS_W-1:0]       rsp_status_reg;
    logic [POS_OUT_W-1:0]      rsp_pos_reg;
    logic signed [VALUE_W-1:0] rsp_value_reg;
    logic [OCC_W-1:0]          rsp_occ_reg;

    logic                      commit;
    logic [CMPW-1:0]           cnt_ext;
    logic [CMPW-1:0]           pos_ext;
    logic [CMPW-1:0]           at;
    logic [CMPW-1:0]           count_next;
    status_t                   status_c;
    logic [CMPW-1:0]           pos_c;
    logic signed [VALUE_W-1:0] value_c;
    mode_t                     mode;
    logic signed [VALUE_W-1:0] sel_value;
    logic                      found;
    logic [CMPW-1:0]           found_idx;

    cell_cmd_t                 cell_cmd   [CAPACITY];
    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]       cell_match;

    assign req.ready    = (state_reg == S_IDLE);
    assign commit       = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);
    assign cnt_ext      = CMPW'(count_reg);
    assign pos_ext      = CMPW'(req_pos_reg);

    // Pick the value of the cell addressed by at.
    always_comb
    begin
        sel_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (CMPW'(i) == at)
                sel_value = sel_value | cell_value[i];
        end
    end

    // Lowest live cell that matches the key.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (cell_match[i] && (CMPW'(i) < cnt_ext))
            begin
                found     = 1'b1;
                found_idx = CMPW'(i);
            end
        end
    end

    // Decode the held request into a result and a chain operation.
    always_comb
    begin
        status_c   = ST_OK;
        pos_c      = '0;
        value_c    = '0;
        count_next = cnt_ext;
        mode       = MODE_NONE;
        at         = '0;
        case (req_kind_reg)
            KIND_INS_FRONT, KIND_INS_END, KIND_INS_AT:
            begin
                if (req_kind_reg == KIND_INS_FRONT)
                    at = '0;
                else if (req_kind_reg == KIND_INS_END)
                    at = cnt_ext;
                else
                    at = pos_ext;
                if (at > cnt_ext)
                    status_c = ST_INVALID;
                else if (cnt_ext >= CAP_EXT)
                    status_c = ST_FULL;
                else
                begin
                    mode       = MODE_INSERT;
                    pos_c      = at;
                    value_c    = req_value_reg;
                    count_next = cnt_ext + CMPW'(1);
                end
            end
            KIND_DEL_FRONT, KIND_DEL_END, KIND_DEL_AT:
            begin
                if (req_kind_reg == KIND_DEL_FRONT)
                    at = '0;
                else if (req_kind_reg == KIND_DEL_END)
                    at = cnt_ext - CMPW'(1);
                else
                    at = pos_ext;
                if ((cnt_ext == '0) || (at >= cnt_ext))
                    status_c = ST_INVALID;
                else
                begin
                    mode       = MODE_DELETE;
                    pos_c      = at;
                    value_c    = sel_value;
                    count_next = cnt_ext - CMPW'(1);
                end
            end
            KIND_READ, KIND_WRITE:
            begin
                at = pos_ext;
                if (at >= cnt_ext)
                    status_c = ST_INVALID;
                else
                begin
                    pos_c = at;
                    if (req_kind_reg == KIND_WRITE)
                    begin
                        mode    = MODE_WRITE;
                        value_c = req_value_reg;
                    end
                    else
                        value_c = sel_value;
                end
            end
            KIND_SEARCH:
            begin
                if (found)
                begin
                    pos_c   = found_idx;
                    value_c = req_value_reg;
                end
                else
                    status_c = ST_NOTFOUND;
            end
            default:
                status_c = ST_INVALID;
        endcase
    end

    // Per-cell operation: shift above the insert point, close the gap on delete.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_cmd[i].load_value = req_value_reg;
            cell_cmd[i].op         = CELL_HOLD;
            if (commit)
            begin
                case (mode)
                    MODE_INSERT:
                    begin
                        if (CMPW'(i) > at)
                            cell_cmd[i].op = CELL_TAKE_LEFT;
                        else if (CMPW'(i) == at)
                            cell_cmd[i].op = CELL_LOAD;
                    end
                    MODE_DELETE:
                    begin
                        if (CMPW'(i) >= at)
                            cell_cmd[i].op = CELL_TAKE_RIGHT;
                    end
                    MODE_WRITE:
                    begin
                        if (CMPW'(i) == at)
                            cell_cmd[i].op = CELL_LOAD;
                    end
                    default:
                        cell_cmd[i].op = CELL_HOLD;
                endcase
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_value;
        logic signed [VALUE_W-1:0] right_value;

        if (g == 0)
        begin : g_first
            assign left_value = req_value_reg;
        end
        else
        begin : g_inner_l
            assign left_value = cell_value[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_value = cell_value[g];
        end
        else
        begin : g_inner_r
            assign right_value = cell_value[g+1];
        end

        ils_cell u_cell (
            .clk         (clk),
            .cmd         (cell_cmd[g]),
            .left_value  (left_value),
            .right_value (right_value),
            .key         (req_value_reg),
            .value       (cell_value[g]),
            .match       (cell_match[g])
        );
    end

    // Sequencer, held request, entry count and response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            req_kind_reg   <= '0;
            req_pos_reg    <= '0;
            req_value_reg  <= '0;
            rsp_status_reg <= '0;
            rsp_pos_reg    <= '0;
            rsp_value_reg  <= '0;
            rsp_occ_reg    <= '0;
        end
        else
        begin
            if (commit)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        req_kind_reg  <= req.kind;
                        req_pos_reg   <= req.position_in;
                        req_value_reg <= req.value_in;
                        state_reg     <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (commit)
                    begin
                        count_reg      <= CW'(count_next);
                        rsp_status_reg <= status_c;
                        rsp_pos_reg    <= POS_OUT_W'(pos_c);
                        rsp_value_reg  <= value_c;
                        rsp_occ_reg    <= OCC_W'(count_next);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.position_out = rsp_pos_reg;
    assign rsp.value_out    = rsp_value_reg;
    assign rsp.occupancy    = rsp_occ_reg;

endmodule
